// ----- src/fbsp_pkg.sv -----
package fbsp_pkg;

   localparam int MAX_PAYLOAD = 32;
   localparam int IDX_W       = 5;
   localparam int LEN_W       = 6;

   localparam logic [7:0] TYPE_SEAT = 8'h10;
   localparam logic [7:0] TYPE_PING = 8'h01;
   localparam logic [7:0] TYPE_PONG = 8'h02;

   localparam logic [1:0] CSR_FRAME_HEAD  = 2'd0;
   localparam logic [1:0] CSR_FRAME_TAIL  = 2'd1;
   localparam logic [1:0] CSR_OWN_ADDRESS = 2'd2;

   localparam logic [7:0]  HEAD_RESET = 8'd250;
   localparam logic [7:0]  TAIL_RESET = 8'd245;
   localparam logic [15:0] ADDR_RESET = 16'd0;

   typedef enum logic [2:0] {
      PH_HEAD    = 3'd0,
      PH_ADDR_LO = 3'd1,
      PH_ADDR_HI = 3'd2,
      PH_LEN     = 3'd3,
      PH_DATA    = 3'd4,
      PH_TAIL    = 3'd5,
      PH_RAW     = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD  = 2'd0,
      KIND_LEN_ERR  = 2'd1,
      KIND_TAIL_ERR = 2'd2
   } kind_type;

   // one delivery or error job handed from parser to reader
   typedef struct packed {
      logic             start;
      kind_type         kind;
      logic [15:0]      addr;
      logic [LEN_W-1:0] len;
      logic             mism;
      logic             ping;
      logic [7:0]       seq;
   } job_type;

   typedef struct packed {
      kind_type         kind;
      logic [15:0]      frame_addr;
      logic [LEN_W-1:0] frame_len;
      logic [IDX_W-1:0] byte_index;
      logic [7:0]       payload_byte;
      logic             last;
      logic             addr_differs;
      logic             pong_request;
      logic [7:0]       pong_seq;
   } result_type;

endpackage

// ----- src/fbsp_payload_ram.sv -----
module fbsp_payload_ram (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [fbsp_pkg::IDX_W-1:0] wr_addr,
   input  logic [7:0]                wr_data,
   input  logic                      rd_en,
   input  logic [fbsp_pkg::IDX_W-1:0] rd_addr,
   output logic [7:0]                rd_data
);

   logic [7:0] mem [fbsp_pkg::MAX_PAYLOAD];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/fbsp_frame_parser.sv -----
module fbsp_frame_parser (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic [7:0]                 rx_byte,
   input  logic [7:0]                 frame_head,
   input  logic [7:0]                 frame_tail,
   input  logic [15:0]                own_address,
   output logic                       wr_en,
   output logic [fbsp_pkg::IDX_W-1:0] wr_addr,
   output logic [7:0]                 wr_data,
   output fbsp_pkg::job_type          job
);

   fbsp_pkg::phase_type phase_ff, phase_in;
   logic [15:0]                addr_ff, addr_in;
   logic [fbsp_pkg::LEN_W-1:0] len_ff, len_in;
   logic [fbsp_pkg::LEN_W-1:0] fill_ff, fill_in;
   logic [fbsp_pkg::LEN_W-1:0] fill_nxt;
   logic [7:0]                 byte0_ff, byte1_ff;
   logic [7:0]                 byte0_fwd, byte1_fwd;
   logic                       store;
   logic                       is_type;

   assign fill_nxt = fill_ff + fbsp_pkg::LEN_W'(1);
   assign is_type  = (rx_byte == fbsp_pkg::TYPE_PING) || (rx_byte == fbsp_pkg::TYPE_PONG)
                     || (rx_byte == fbsp_pkg::TYPE_SEAT);

   // the byte being written now may be entry 0 or 1 of a frame that closes on it
   assign byte0_fwd = (wr_en && wr_addr == '0) ? rx_byte : byte0_ff;
   assign byte1_fwd = (wr_en && wr_addr == fbsp_pkg::IDX_W'(1)) ? rx_byte : byte1_ff;

   always_comb begin
      phase_in = phase_ff;
      addr_in  = addr_ff;
      len_in   = len_ff;
      fill_in  = fill_ff;
      store    = 1'b0;
      wr_addr  = fill_ff[fbsp_pkg::IDX_W-1:0];
      wr_data  = rx_byte;
      job      = '0;
      job.kind = fbsp_pkg::KIND_PAYLOAD;
      job.addr = addr_ff;
      job.len  = len_ff;
      job.mism = (addr_ff != own_address);
      job.ping = (len_ff >= fbsp_pkg::LEN_W'(2)) && (byte0_fwd == fbsp_pkg::TYPE_PING);
      job.seq  = byte1_fwd;
      if (accept) begin
         unique case (phase_ff)
            fbsp_pkg::PH_HEAD: begin
               priority if (rx_byte == frame_head) begin
                  phase_in = fbsp_pkg::PH_ADDR_LO;
                  addr_in  = '0;
                  len_in   = '0;
                  fill_in  = '0;
               end else if (is_type) begin
                  phase_in = fbsp_pkg::PH_RAW;
                  addr_in  = own_address;
                  len_in   = (rx_byte == fbsp_pkg::TYPE_SEAT) ? fbsp_pkg::LEN_W'(4)
                                                               : fbsp_pkg::LEN_W'(2);
                  store    = 1'b1;
                  wr_addr  = '0;
                  fill_in  = fbsp_pkg::LEN_W'(1);
               end else begin
                  phase_in = fbsp_pkg::PH_HEAD;
               end
            end
            fbsp_pkg::PH_ADDR_LO: begin
               addr_in  = {8'd0, rx_byte};
               phase_in = fbsp_pkg::PH_ADDR_HI;
            end
            fbsp_pkg::PH_ADDR_HI: begin
               addr_in  = {rx_byte, addr_ff[7:0]};
               phase_in = fbsp_pkg::PH_LEN;
            end
            fbsp_pkg::PH_LEN: begin
               fill_in = '0;
               len_in  = rx_byte[fbsp_pkg::LEN_W-1:0];
               if (rx_byte == 8'd0 || rx_byte > 8'(fbsp_pkg::MAX_PAYLOAD)) begin
                  job          = '0;
                  job.start    = 1'b1;
                  job.kind     = fbsp_pkg::KIND_LEN_ERR;
                  phase_in     = fbsp_pkg::PH_HEAD;
               end else begin
                  phase_in = fbsp_pkg::PH_DATA;
               end
            end
            fbsp_pkg::PH_DATA: begin
               store   = (fill_ff < fbsp_pkg::LEN_W'(fbsp_pkg::MAX_PAYLOAD));
               fill_in = fill_nxt;
               if (fill_nxt >= len_ff) begin
                  phase_in = fbsp_pkg::PH_TAIL;
               end
            end
            fbsp_pkg::PH_TAIL: begin
               if (rx_byte == frame_tail) begin
                  job.start = 1'b1;
               end else begin
                  job       = '0;
                  job.start = 1'b1;
                  job.kind  = fbsp_pkg::KIND_TAIL_ERR;
               end
               phase_in = fbsp_pkg::PH_HEAD;
            end
            fbsp_pkg::PH_RAW: begin
               store   = (fill_ff < fbsp_pkg::LEN_W'(fbsp_pkg::MAX_PAYLOAD));
               fill_in = fill_nxt;
               if (fill_nxt >= len_ff) begin
                  job.start = 1'b1;
                  phase_in  = fbsp_pkg::PH_HEAD;
               end
            end
            default: begin
               phase_in = fbsp_pkg::PH_HEAD;
            end
         endcase
      end
   end

   assign wr_en = store;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= fbsp_pkg::PH_HEAD;
         addr_ff  <= '0;
         len_ff   <= '0;
         fill_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         addr_ff  <= addr_in;
         len_ff   <= len_in;
         fill_ff  <= fill_in;
      end
   end

   // copies of the first two entries for the ping check and the echoed sequence
   always_ff @(posedge clock) begin
      byte0_ff <= byte0_fwd;
      byte1_ff <= byte1_fwd;
   end

endmodule

// ----- src/fbsp_frame_reader.sv -----
module fbsp_frame_reader (
   input  logic                       clock,
   input  logic                       reset,
   input  fbsp_pkg::job_type          job,
   output logic                       busy,
   output logic                       rd_en,
   output logic [fbsp_pkg::IDX_W-1:0] rd_addr,
   input  logic [7:0]                 rd_data,
   output logic                       out_valid,
   input  logic                       out_ready,
   output fbsp_pkg::result_type       result
);

   fbsp_pkg::job_type          job_ff;
   logic                       active_ff, active_in;
   logic                       rd_pend_ff, rd_pend_in;
   logic [fbsp_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic                       out_valid_ff, out_valid_in;
   fbsp_pkg::result_type       result_ff, result_in;
   logic                       issue;
   logic                       is_last;

   // one read in flight at a time; only issued when the output register frees up
   assign issue   = active_ff && !rd_pend_ff && (!out_valid_ff || out_ready);
   assign is_last = (job_ff.kind != fbsp_pkg::KIND_PAYLOAD)
                    || ({1'b0, idx_ff} + fbsp_pkg::LEN_W'(1) == job_ff.len);
   assign rd_en   = issue && (job_ff.kind == fbsp_pkg::KIND_PAYLOAD);
   assign rd_addr = idx_ff;

   always_comb begin
      active_in    = active_ff;
      rd_pend_in   = issue;
      idx_in       = idx_ff;
      result_in    = result_ff;
      out_valid_in = out_valid_ff && !out_ready;
      if (job.start && !active_ff) begin
         active_in = 1'b1;
         idx_in    = '0;
      end
      if (rd_pend_ff) begin
         out_valid_in = 1'b1;
         result_in    = '0;
         result_in.kind = job_ff.kind;
         result_in.last = is_last;
         if (job_ff.kind == fbsp_pkg::KIND_PAYLOAD) begin
            result_in.frame_addr    = job_ff.addr;
            result_in.frame_len     = job_ff.len;
            result_in.byte_index    = idx_ff;
            result_in.payload_byte  = rd_data;
            result_in.addr_differs  = job_ff.mism;
            result_in.pong_request  = is_last && job_ff.ping;
            result_in.pong_seq      = (is_last && job_ff.ping) ? job_ff.seq : 8'd0;
         end
         idx_in = idx_ff + fbsp_pkg::IDX_W'(1);
         if (is_last) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rd_pend_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rd_pend_ff   <= rd_pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      result_ff <= result_in;
      if (job.start && !active_ff) begin
         job_ff <= job;
      end
   end

   assign busy      = active_ff;
   assign out_valid = out_valid_ff;
   assign result    = result_ff;

   a_pend_needs_active: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> active_ff)
      else $error("read in flight with no active job");

   a_pend_out_free: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> !out_valid_ff)
      else $error("read data returns into a full output register");

   a_pend_loads: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |=> out_valid_ff)
      else $error("returned read data not loaded");

   a_job_when_idle: assert property (@(posedge clock) disable iff (reset)
      job.start |-> !active_ff)
      else $error("job started while reader busy");

endmodule

// ----- src/framed_byte_stream_parser_unit.sv -----
// Parses a received byte stream into addressed frames (head, address low, address high,
// length, payload, tail) and raw frames (ping or pong type byte: 2 bytes, seat-status
// type byte: 4 bytes, own address implied). Header, length and payload bytes are taken
// one a cycle while no frame is being read out. A byte that closes a good frame starts
// delivery of its payload from the 32-entry payload RAM: each result beat goes through a
// RAM read, then the output register, and waits while rsp_ready is low, and no byte is
// accepted until the last read of the frame has returned. A length or tail error gives
// one beat. Configuration writes are accepted every cycle and are meant to be made while
// the block is idle.
module framed_byte_stream_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_frame_addr,
   output logic [5:0]  rsp_frame_len,
   output logic [4:0]  rsp_byte_index,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_last,
   output logic        rsp_addr_differs,
   output logic        rsp_pong_request,
   output logic [7:0]  rsp_pong_seq,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic [7:0]                 head_ff, tail_ff;
   logic [15:0]                own_addr_ff;
   logic                       accept;
   logic                       busy;
   logic                       wr_en, rd_en;
   logic [fbsp_pkg::IDX_W-1:0] wr_addr, rd_addr;
   logic [7:0]                 wr_data, rd_data;
   fbsp_pkg::job_type          job;
   fbsp_pkg::result_type       result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= fbsp_pkg::HEAD_RESET;
         tail_ff     <= fbsp_pkg::TAIL_RESET;
         own_addr_ff <= fbsp_pkg::ADDR_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            fbsp_pkg::CSR_FRAME_HEAD:  head_ff     <= csr_data[7:0];
            fbsp_pkg::CSR_FRAME_TAIL:  tail_ff     <= csr_data[7:0];
            fbsp_pkg::CSR_OWN_ADDRESS: own_addr_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // payload RAM is never written while a frame is being read out
   assign req_ready = !busy;
   assign accept    = req_valid && !busy;

   fbsp_frame_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .rx_byte     (req_rx_byte),
      .frame_head  (head_ff),
      .frame_tail  (tail_ff),
      .own_address (own_addr_ff),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .job         (job)
   );

   fbsp_payload_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   fbsp_frame_reader u_reader (
      .clock     (clock),
      .reset     (reset),
      .job       (job),
      .busy      (busy),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .result    (result)
   );

   assign rsp_kind          = result.kind;
   assign rsp_frame_addr    = result.frame_addr;
   assign rsp_frame_len     = result.frame_len;
   assign rsp_byte_index    = result.byte_index;
   assign rsp_payload_byte  = result.payload_byte;
   assign rsp_last          = result.last;
   assign rsp_addr_differs  = result.addr_differs;
   assign rsp_pong_request  = result.pong_request;
   assign rsp_pong_seq      = result.pong_seq;

endmodule

// ----- sim/tb_framed_byte_stream_parser_unit.sv -----
`timescale 1ns / 100ps

module tb_framed_byte_stream_parser_unit;

   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam int unsigned SETTLE_CYCLES = 80;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [15:0] rsp_frame_addr;
   logic [5:0]  rsp_frame_len;
   logic [4:0]  rsp_byte_index;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_last;
   logic        rsp_addr_differs;
   logic        rsp_pong_request;
   logic [7:0]  rsp_pong_seq;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = fbsp_pkg::CSR_FRAME_HEAD;
   logic [15:0] csr_data = 16'h0000;

   framed_byte_stream_parser_unit dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // parser mirror: configuration and frame state
   logic [7:0]          cfg_head = fbsp_pkg::HEAD_RESET;
   logic [7:0]          cfg_tail = fbsp_pkg::TAIL_RESET;
   logic [15:0]         cfg_own_addr = fbsp_pkg::ADDR_RESET;
   fbsp_pkg::phase_type parse_state = fbsp_pkg::PH_HEAD;
   logic [15:0]         cur_addr = 16'h0000;
   logic [5:0]          cur_len = 6'd0;
   int unsigned         cur_fill = 0;
   logic [7:0]          frame_bytes [fbsp_pkg::MAX_PAYLOAD];

   logic [7:0]           rx_backlog [$];
   fbsp_pkg::result_type due_results [$];
   fbsp_pkg::result_type want_beat;
   int unsigned          fail_count = 0;
   int unsigned          cycle_count = 0;
   bit                   steady = 1'b0;

   logic [7:0] opening_bytes [29] = '{
      fbsp_pkg::TYPE_PING, 8'hAB,
      fbsp_pkg::TYPE_SEAT, 8'h00, 8'hFF, 8'h7E,
      fbsp_pkg::TYPE_PONG, 8'h55,
      8'hFA, 8'h34, 8'h12, 8'h02, fbsp_pkg::TYPE_PING, 8'h9C, 8'hF5,
      8'hFA, 8'h00, 8'h00, 8'h00,
      8'hFA, 8'hFF, 8'hFF, 8'h21,
      8'hFA, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h00
   };

   function automatic void add_error(input fbsp_pkg::kind_type k);
      fbsp_pkg::result_type beat;
      beat = '0;
      beat.kind = k;
      beat.last = 1'b1;
      due_results.push_back(beat);
   endfunction

   function automatic void emit_frame();
      fbsp_pkg::result_type beat;
      logic mism;
      logic ping;
      int k;
      mism = (cur_addr != cfg_own_addr);
      ping = (cur_len >= 2) && (frame_bytes[0] == fbsp_pkg::TYPE_PING);
      for (k = 0; k < cur_len; k++) begin
         beat = '0;
         beat.kind = fbsp_pkg::KIND_PAYLOAD;
         beat.frame_addr = cur_addr;
         beat.frame_len = cur_len;
         beat.byte_index = 5'(k);
         beat.payload_byte = frame_bytes[k];
         beat.last = (k + 1 == cur_len);
         beat.addr_differs = mism;
         beat.pong_request = beat.last && ping;
         beat.pong_seq = beat.pong_request ? frame_bytes[1] : 8'h00;
         due_results.push_back(beat);
      end
   endfunction

   function automatic void store_payload(input logic [7:0] b);
      if (cur_fill < fbsp_pkg::MAX_PAYLOAD) frame_bytes[cur_fill] = b;
      cur_fill++;
   endfunction

   function automatic void track_rx_byte(input logic [7:0] b);
      case (parse_state)
         fbsp_pkg::PH_HEAD: begin
            // the head comparison wins over the raw type bytes
            if (b == cfg_head) begin
               parse_state = fbsp_pkg::PH_ADDR_LO;
               cur_addr = 16'h0000;
               cur_len = 6'd0;
               cur_fill = 0;
            end else if (b == fbsp_pkg::TYPE_PING || b == fbsp_pkg::TYPE_PONG
                         || b == fbsp_pkg::TYPE_SEAT) begin
               cur_addr = cfg_own_addr;
               cur_len = (b == fbsp_pkg::TYPE_SEAT) ? 6'd4 : 6'd2;
               frame_bytes[0] = b;
               cur_fill = 1;
               parse_state = fbsp_pkg::PH_RAW;
            end
         end
         fbsp_pkg::PH_ADDR_LO: begin
            cur_addr = {8'h00, b};
            parse_state = fbsp_pkg::PH_ADDR_HI;
         end
         fbsp_pkg::PH_ADDR_HI: begin
            cur_addr[15:8] = b;
            parse_state = fbsp_pkg::PH_LEN;
         end
         fbsp_pkg::PH_LEN: begin
            cur_fill = 0;
            cur_len = b[5:0];
            if (b == 8'd0 || b > fbsp_pkg::MAX_PAYLOAD) begin
               add_error(fbsp_pkg::KIND_LEN_ERR);
               parse_state = fbsp_pkg::PH_HEAD;
            end else begin
               parse_state = fbsp_pkg::PH_DATA;
            end
         end
         fbsp_pkg::PH_DATA: begin
            store_payload(b);
            if (cur_fill >= cur_len) parse_state = fbsp_pkg::PH_TAIL;
         end
         fbsp_pkg::PH_TAIL: begin
            if (b == cfg_tail) emit_frame();
            else add_error(fbsp_pkg::KIND_TAIL_ERR);
            parse_state = fbsp_pkg::PH_HEAD;
         end
         fbsp_pkg::PH_RAW: begin
            store_payload(b);
            if (cur_fill >= cur_len) begin
               emit_frame();
               parse_state = fbsp_pkg::PH_HEAD;
            end
         end
         default: parse_state = fbsp_pkg::PH_HEAD;
      endcase
   endfunction

   // mostly short frames, now and then the full buffer
   function automatic int unsigned payload_len_choice();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 4) return fbsp_pkg::MAX_PAYLOAD;
      if (r < 20) return $urandom_range(9, fbsp_pkg::MAX_PAYLOAD - 1);
      return $urandom_range(1, 8);
   endfunction

   // addressed frame, cut down to its first keep bytes
   function automatic int unsigned queue_addressed(input logic [7:0] len_byte,
                                                   input bit good_tail,
                                                   input int unsigned keep);
      logic [7:0]  seq [$];
      logic [15:0] addr;
      int unsigned i;
      addr = $urandom_range(0, 1) ? cfg_own_addr : 16'($urandom);
      seq.push_back(cfg_head);
      seq.push_back(addr[7:0]);
      seq.push_back(addr[15:8]);
      seq.push_back(len_byte);
      if (len_byte != 8'd0 && len_byte <= fbsp_pkg::MAX_PAYLOAD) begin
         for (i = 0; i < len_byte; i++) begin
            if (i == 0 && $urandom_range(0, 9) < 3) seq.push_back(fbsp_pkg::TYPE_PING);
            else seq.push_back(8'($urandom));
         end
         seq.push_back(good_tail ? cfg_tail : cfg_tail ^ 8'($urandom_range(1, 255)));
      end
      while (seq.size() > keep) void'(seq.pop_back());
      foreach (seq[j]) rx_backlog.push_back(seq[j]);
      return seq.size();
   endfunction

   function automatic void queue_random(input int unsigned target);
      int unsigned counted;
      int unsigned pick;
      int unsigned len;
      logic [7:0]  kind_byte;
      logic [7:0]  bad_len;
      counted = 0;
      while (counted < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            counted += queue_addressed(8'(payload_len_choice()),
                                       $urandom_range(0, 99) < 85, 999);
         end else if (pick < 65) begin
            case ($urandom_range(0, 2))
               0: kind_byte = fbsp_pkg::TYPE_PING;
               1: kind_byte = fbsp_pkg::TYPE_PONG;
               default: kind_byte = fbsp_pkg::TYPE_SEAT;
            endcase
            rx_backlog.push_back(kind_byte);
            repeat ((kind_byte == fbsp_pkg::TYPE_SEAT) ? 3 : 1)
               rx_backlog.push_back(8'($urandom));
            counted += (kind_byte == fbsp_pkg::TYPE_SEAT) ? 4 : 2;
         end else if (pick < 73) begin
            bad_len = $urandom_range(0, 1) ? 8'd0 :
                      8'($urandom_range(fbsp_pkg::MAX_PAYLOAD + 1, 255));
            counted += queue_addressed(bad_len, 1'b1, 999);
         end else if (pick < 85) begin
            len = payload_len_choice();
            counted += queue_addressed(8'(len), 1'b1, $urandom_range(1, len + 4));
         end else begin
            // line noise, not counted
            repeat ($urandom_range(1, 3)) rx_backlog.push_back(8'($urandom));
         end
      end
   endfunction

   function automatic bit link_busy();
      return rx_backlog.size() != 0 || req_valid || due_results.size() != 0;
   endfunction

   task automatic settle();
      do begin
         while (link_busy()) @(posedge clock);
         repeat (SETTLE_CYCLES) @(posedge clock);
      end while (link_busy());
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         fbsp_pkg::CSR_FRAME_HEAD:  cfg_head = value[7:0];
         fbsp_pkg::CSR_FRAME_TAIL:  cfg_tail = value[7:0];
         fbsp_pkg::CSR_OWN_ADDRESS: cfg_own_addr = value;
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input logic [7:0] head, input logic [7:0] tail,
                             input logic [15:0] own);
      // upper bits of the byte-wide registers carry junk
      write_reg(fbsp_pkg::CSR_FRAME_HEAD, {8'($urandom), head});
      write_reg(fbsp_pkg::CSR_FRAME_TAIL, {8'($urandom), tail});
      write_reg(fbsp_pkg::CSR_OWN_ADDRESS, own);
   endtask

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   // byte driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) track_rx_byte(req_rx_byte);
         if (!req_valid || req_ready) begin
            if (rx_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= 37)) begin
               req_valid <= 1'b1;
               req_rx_byte <= rx_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               $error("result beat with none expected: kind %0d", rsp_kind);
               fail_count++;
            end else begin
               want_beat = due_results.pop_front();
               check_field("kind", want_beat.kind, rsp_kind);
               check_field("frame_addr", want_beat.frame_addr, rsp_frame_addr);
               check_field("frame_len", want_beat.frame_len, rsp_frame_len);
               check_field("byte_index", want_beat.byte_index, rsp_byte_index);
               check_field("payload_byte", want_beat.payload_byte, rsp_payload_byte);
               check_field("last", want_beat.last, rsp_last);
               check_field("addr_differs", want_beat.addr_differs, rsp_addr_differs);
               check_field("pong_request", want_beat.pong_request, rsp_pong_request);
               check_field("pong_seq", want_beat.pong_seq, rsp_pong_seq);
            end
         end
         rsp_ready <= steady || ($urandom_range(0, 99) >= 37);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_bytes[i]) rx_backlog.push_back(opening_bytes[i]);
      queue_random(80);
      settle();

      // head equal to the ping type byte
      set_config(fbsp_pkg::TYPE_PING, 8'h00, 16'hFFFF);
      queue_random(80);
      settle();

      steady = 1'b1;
      set_config(8'h00, 8'hFF, 16'($urandom));
      queue_random(80);
      settle();
      steady = 1'b0;

      set_config(8'hFF, fbsp_pkg::TYPE_SEAT, 16'($urandom));
      queue_random(80);
      settle();

      set_config(8'($urandom), 8'($urandom), 16'($urandom));
      queue_random(80);
      settle();

      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
